// File: rtl/phcal_pkg.sv
// ----------------------------------------------------------------------------
// phcal_pkg
// Types and constants shared by the pH probe conversion core and its divider.
// ----------------------------------------------------------------------------
package phcal_pkg;

  // Shared divider geometry: the dividend covers 2*|probe|*100000 + |slope|.
  localparam int DIVD_W = 30;
  localparam int DVS_W  = 17;

  // Input item kinds carried on tuser.
  localparam logic [2:0] ACT_MEASURE  = 3'd0;
  localparam logic [2:0] ACT_ARM_LOW  = 3'd1;
  localparam logic [2:0] ACT_ARM_MID  = 3'd2;
  localparam logic [2:0] ACT_ARM_HIGH = 3'd3;
  localparam logic [2:0] ACT_LOAD     = 3'd4;

  // Armed capture codes.
  localparam logic [1:0] ARM_NONE = 2'd0;
  localparam logic [1:0] ARM_LOW  = 2'd1;
  localparam logic [1:0] ARM_MID  = 2'd2;
  localparam logic [1:0] ARM_HIGH = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_IDEAL_SLOPE = 1'b0;
  localparam logic CFG_SWITCH_DROP = 1'b1;

  // Arithmetic constants.
  localparam logic [16:0] K_ADC        = 17'd600;
  localparam logic [16:0] K_SLOPE      = 17'd10000;
  localparam logic [16:0] K_TEMP       = 17'd1985;
  localparam logic [16:0] K_PH         = 17'd100000;
  localparam logic [16:0] DEN_ACID     = 17'd285;
  localparam logic [16:0] DEN_ALK      = 17'd232;
  localparam logic [16:0] DEN_TEMP     = 17'd10000;
  localparam logic signed [15:0] TEMP_REF   = 16'sd2500;
  localparam logic signed [13:0] ACID_LIMIT = -14'sd25;
  localparam logic signed [15:0] PH_NEUTRAL = 16'sd7000;
  localparam logic [12:0] IDEAL_SLOPE_RST = 13'd5918;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_POST,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    OP_ADC,
    OP_BASE,
    OP_TEMP,
    OP_PH
  } op_e;

  typedef struct packed {
    logic               start;
    logic [DIVD_W-1:0]  dividend;
    logic [DVS_W-1:0]   divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIVD_W-1:0]  quotient;
  } div_rsp_t;

endpackage

// File: rtl/phcal_div.sv
// ----------------------------------------------------------------------------
// phcal_div
// Restoring unsigned divider, one quotient bit per cycle, shared by all steps.
// ----------------------------------------------------------------------------
module phcal_div
  import phcal_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [DIVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W:0]    rem_q, rem_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DVS_W:0]    rem_sh;
  logic              geq;

  // The partial remainder stays below the divisor, so the shifted value fits.
  assign rem_sh = {rem_q[DVS_W-1:0], dvd_q[DIVD_W-1]};
  assign geq    = rem_sh >= {1'b0, dvs_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
      rem_d  = '0;
      cnt_d  = CNT_W'(DIVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      dvd_d = {dvd_q[DIVD_W-2:0], geq};
      rem_d = geq ? rem_sh - {1'b0, dvs_q} : rem_sh;
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = dvd_q;

endmodule

// File: rtl/ph_probe_convert_calibrate_core.sv
// ----------------------------------------------------------------------------
// ph_probe_convert_calibrate_core
// pH probe conversion with two-point electrode calibration.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  s_axis    in         tvalid / tready         tuser: action; tdata: sample fields
//  m_axis    out        tvalid / tready         tdata: pH result fields
//  cfg       in         cfg_we_i (no wait)      cfg_addr_i, cfg_wdata_i
//
//  A measurement runs two to four divisions on the shared restoring divider,
//  each going through operand setup, the quotient bits, hand-off and use; a
//  zero slope skips the pH division and an uncalibrated side skips the slope
//  division. Other actions run no division and go straight to the output.
//  The input is ready only while the sequencer is idle. A finished result
//  waits in the output register; the sequencer stalls there only while a
//  previous result is still not taken. Reset clears the calibration points,
//  the armed capture and sets the registers to their defaults.
// ----------------------------------------------------------------------------
module ph_probe_convert_calibrate_core
  import phcal_pkg::*;
#(
  parameter int ADC_WIDTH = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // adc_raw[11:0], battery_mv[24:12], temp_centi_c[39:25], load_low_mv[52:40],
  // load_mid_mv[65:53], load_high_mv[78:66], zero fill [79]
  input  logic [79:0] s_axis_tdata,
  // action[2:0]
  input  logic [2:0]  s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // ph_milli[15:0], probe_mv[28:16], slope_centi[44:29], pending_point[46:45],
  // captured[47], slope_error[48], zero fill [55:49]
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [12:0] cfg_wdata_i
);

  localparam logic [16:0] FS = 17'((1 << ADC_WIDTH) - 1);

  state_e state_q, state_d;
  op_e    op_q, op_d;

  logic [12:0] ideal_q;
  logic [7:0]  drop_q;

  logic signed [12:0] low_q, low_d, mid_q, mid_d, high_q, high_d;
  logic [1:0]  arm_q, arm_d;

  logic [15:0] raw_q, raw_d;
  logic [12:0] batt_q, batt_d;
  logic signed [14:0] temp_q, temp_d;
  logic        meas_q, meas_d;
  logic        alk_q, alk_d;
  logic        neg_q, neg_d;
  logic signed [12:0] probe_q, probe_d;
  logic signed [19:0] base_q, base_d;
  logic signed [15:0] slope_q, slope_d;
  logic signed [15:0] ph_q, ph_d;
  logic        err_q, err_d;

  logic [55:0] out_q, out_d;
  logic        out_vld_q, out_vld_d;

  div_req_t div_req;
  div_rsp_t div_rsp;

  // Operand selection and the constant multiplier in front of the divider.
  logic signed [16:0] opnd;
  logic [15:0] mag;
  logic [16:0] kmul;
  logic [16:0] den_abs;
  logic        floor_div;
  logic        neg_sel;
  logic [32:0] prod;
  logic signed [13:0] pdiff;
  logic signed [15:0] tdiff;

  // Post-division values.
  logic signed [30:0] sq;
  logic signed [13:0] probe_w;
  logic signed [20:0] slope_sum;
  logic signed [31:0] ph_full;
  logic        s_acc;
  logic        cap;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    pdiff = alk_q ? ({mid_q[12], mid_q} - {high_q[12], high_q})
                  : ({low_q[12], low_q} - {mid_q[12], mid_q});
    tdiff = {temp_q[14], temp_q} - TEMP_REF;
    opnd      = '0;
    kmul      = K_ADC;
    den_abs   = FS;
    floor_div = 1'b0;
    neg_sel   = 1'b0;
    case (op_q)
      OP_ADC: begin
        opnd      = {1'b0, raw_q};
        kmul      = K_ADC;
        den_abs   = FS;
        floor_div = 1'b1;
      end
      OP_BASE: begin
        opnd    = {{3{pdiff[13]}}, pdiff};
        kmul    = K_SLOPE;
        den_abs = alk_q ? DEN_ALK : DEN_ACID;
        neg_sel = pdiff[13];
      end
      OP_TEMP: begin
        opnd    = {tdiff[15], tdiff};
        kmul    = K_TEMP;
        den_abs = DEN_TEMP;
        neg_sel = tdiff[15];
      end
      OP_PH: begin
        opnd    = {{4{probe_q[12]}}, probe_q};
        kmul    = K_PH;
        den_abs = slope_q[15] ? 17'(-{slope_q[15], slope_q}) : {1'b0, slope_q};
        neg_sel = probe_q[12] ^ slope_q[15];
      end
      default: begin
        opnd = '0;
      end
    endcase
    mag  = opnd[16] ? 16'(-opnd) : opnd[15:0];
    prod = 33'(mag) * 33'(kmul);
  end

  // Quotient with its sign restored; also the probe voltage after the sample.
  always_comb begin
    sq = neg_q ? -$signed({1'b0, div_rsp.quotient}) : $signed({1'b0, div_rsp.quotient});
    probe_w = $signed({2'b00, div_rsp.quotient[9:0], 2'b00})
            - $signed({2'b00, batt_q[12:1]})
            + $signed({6'b000000, drop_q});
    slope_sum = {base_q[19], base_q} + sq[20:0];
    ph_full   = 32'(PH_NEUTRAL) - {sq[30], sq};
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    low_d     = low_q;
    mid_d     = mid_q;
    high_d    = high_q;
    arm_d     = arm_q;
    raw_d     = raw_q;
    batt_d    = batt_q;
    temp_d    = temp_q;
    meas_d    = meas_q;
    alk_d     = alk_q;
    neg_d     = neg_q;
    probe_d   = probe_q;
    base_d    = base_q;
    slope_d   = slope_q;
    ph_d      = ph_q;
    err_d     = err_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && !m_axis_tready;
    cap       = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = floor_div ? prod[DIVD_W-1:0]
                                 : {prod[DIVD_W-2:0], 1'b0} + DIVD_W'(den_abs);
    div_req.divisor  = floor_div ? den_abs : {den_abs[DVS_W-2:0], 1'b0};

    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          raw_d  = {4'b0000, s_axis_tdata[11:0]} & FS[15:0];
          batt_d = s_axis_tdata[24:12];
          temp_d = s_axis_tdata[39:25];
          meas_d = 1'b0;
          err_d  = 1'b0;
          state_d = ST_DONE;
          case (s_axis_tuser)
            ACT_MEASURE: begin
              meas_d  = 1'b1;
              op_d    = OP_ADC;
              state_d = ST_MUL;
            end
            ACT_ARM_LOW, ACT_ARM_MID, ACT_ARM_HIGH: begin
              arm_d = s_axis_tuser[1:0];
            end
            ACT_LOAD: begin
              low_d  = s_axis_tdata[52:40];
              mid_d  = s_axis_tdata[65:53];
              high_d = s_axis_tdata[78:66];
            end
            default: begin
              arm_d = arm_q;
            end
          endcase
        end
      end
      ST_MUL: begin
        div_req.start = 1'b1;
        neg_d   = neg_sel;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_POST;
        end
      end
      ST_POST: begin
        state_d = ST_MUL;
        case (op_q)
          OP_ADC: begin
            probe_d = probe_w[12:0];
            if (probe_w > ACID_LIMIT && low_q != '0 && mid_q != '0) begin
              alk_d = 1'b0;
              op_d  = OP_BASE;
            end else if (!(probe_w > ACID_LIMIT) && mid_q != '0 && high_q != '0) begin
              alk_d = 1'b1;
              op_d  = OP_BASE;
            end else begin
              base_d = {7'b0000000, ideal_q};
              op_d   = OP_TEMP;
            end
          end
          OP_BASE: begin
            base_d = sq[19:0];
            op_d   = OP_TEMP;
          end
          OP_TEMP: begin
            if (slope_sum > 21'sd32767) begin
              slope_d = 16'sh7fff;
            end else if (slope_sum < -21'sd32768) begin
              slope_d = 16'sh8000;
            end else begin
              slope_d = slope_sum[15:0];
            end
            if (slope_sum == '0) begin
              // A zero slope saturates pH opposite to the sign of the probe voltage.
              err_d   = 1'b1;
              state_d = ST_DONE;
              if (probe_q > 13'sd0) begin
                ph_d = 16'sh8000;
              end else if (probe_q < 13'sd0) begin
                ph_d = 16'sh7fff;
              end else begin
                ph_d = PH_NEUTRAL;
              end
            end else begin
              op_d = OP_PH;
            end
          end
          OP_PH: begin
            if (ph_full > 32'sd32767) begin
              ph_d = 16'sh7fff;
            end else if (ph_full < -32'sd32768) begin
              ph_d = 16'sh8000;
            end else begin
              ph_d = ph_full[15:0];
            end
            state_d = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          state_d   = ST_IDLE;
          if (meas_q) begin
            // The pH above used the points held before this capture.
            cap = arm_q != ARM_NONE;
            case (arm_q)
              ARM_LOW:  low_d  = probe_q;
              ARM_MID:  mid_d  = probe_q;
              ARM_HIGH: high_d = probe_q;
              default:  low_d  = low_q;
            endcase
            arm_d = ARM_NONE;
            out_d = {7'b0000000, err_q, cap, ARM_NONE, slope_q, probe_q, ph_q};
          end else begin
            out_d = {7'b0000000, 1'b0, 1'b0, arm_q, 16'h0000, 13'h0000, 16'h0000};
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_ADC;
      out_vld_q <= 1'b0;
      arm_q     <= ARM_NONE;
      low_q     <= '0;
      mid_q     <= '0;
      high_q    <= '0;
      ideal_q   <= IDEAL_SLOPE_RST;
      drop_q    <= '0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      out_vld_q <= out_vld_d;
      arm_q     <= arm_d;
      low_q     <= low_d;
      mid_q     <= mid_d;
      high_q    <= high_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_IDEAL_SLOPE: ideal_q <= cfg_wdata_i;
          CFG_SWITCH_DROP: drop_q  <= cfg_wdata_i[7:0];
          default:         drop_q  <= drop_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q   <= raw_d;
    batt_q  <= batt_d;
    temp_q  <= temp_d;
    meas_q  <= meas_d;
    alk_q   <= alk_d;
    neg_q   <= neg_d;
    probe_q <= probe_d;
    base_q  <= base_d;
    slope_q <= slope_d;
    ph_q    <= ph_d;
    err_q   <= err_d;
    out_q   <= out_d;
  end

  phcal_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule
